>>> hdl/itmr_pkg.sv
// Package: shared beat types, operation codes and node word layout for the tree mass router.
`timescale 1ns / 1ps

package itmr_pkg;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_ROUTE  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_REPORT = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [6:0]         node_index;
        logic [2:0]         split_attribute;
        logic signed [15:0] split_value;
        logic               node_is_leaf;
        logic               point_present;
        logic signed [15:0] attr_0;
        logic signed [15:0] attr_1;
        logic signed [15:0] attr_2;
        logic signed [15:0] attr_3;
        logic signed [15:0] attr_4;
        logic signed [15:0] attr_5;
    } in_item_t;

    typedef struct packed {
        logic        leaf_found;
        logic [6:0]  leaf_node;
        logic [15:0] node_mass;
        logic [15:0] smallest_leaf;
        logic [15:0] largest_leaf;
    } out_item_t;

    // One node table entry; scan_open marks a node reached by the scan and not a leaf.
    typedef struct packed {
        logic               scan_open;
        logic               leaf;
        logic signed [15:0] threshold;
        logic [2:0]         attribute;
    } node_word_t;

    localparam int NODE_W = $bits(node_word_t);

endpackage

>>> hdl/itmr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module itmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/itmr_ctrl.sv
// Sequencer: init sweep, node load, mass clear, tree walk, mass read and leaf scan.
`timescale 1ns / 1ps

module itmr_ctrl #(
    parameter int TREE_HEIGHT = 6,
    parameter int ATTRIBUTES  = 6,
    parameter int MASS_BITS   = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  itmr_pkg::in_item_t          in_data,
    output logic                        res_valid,
    input  logic                        res_take,
    output itmr_pkg::out_item_t         res_data,
    output logic                        node_wr_en,
    output logic [TREE_HEIGHT:0]        node_wr_addr,
    output itmr_pkg::node_word_t        node_wr_data,
    output logic                        node_rd_en,
    output logic [TREE_HEIGHT:0]        node_rd_addr,
    input  itmr_pkg::node_word_t        node_rd_data,
    output logic                        cnt_wr_en,
    output logic [TREE_HEIGHT:0]        cnt_wr_addr,
    output logic [MASS_BITS-1:0]        cnt_wr_data,
    output logic                        cnt_rd_en,
    output logic [TREE_HEIGHT:0]        cnt_rd_addr,
    input  logic [MASS_BITS-1:0]        cnt_rd_data
);

    import itmr_pkg::*;

    localparam int NB           = TREE_HEIGHT + 1;
    localparam int NODES        = (2 ** NB) - 1;
    localparam int FIRST_BOTTOM = (2 ** TREE_HEIGHT) - 1;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_RDM   = 4'd4;
    localparam logic [3:0] S_SPAR  = 4'd5;
    localparam logic [3:0] S_SNODE = 4'd6;
    localparam logic [3:0] S_SEVAL = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    function automatic logic [MASS_BITS-1:0] sat_inc(input logic [MASS_BITS-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [NB-1:0]        n_reg, n_next;
    logic [MASS_BITS-1:0] total_reg, total_next;
    logic [MASS_BITS-1:0] small_reg, small_next;
    logic [MASS_BITS-1:0] large_reg, large_next;
    logic                 open_p_reg, open_p_next;
    in_item_t             item_reg, item_next;
    out_item_t            res_reg, res_next;

    logic                 accept;
    logic                 idx_ok;
    logic                 n_last;
    logic                 n_bottom;
    logic                 node_leaf;
    logic [MASS_BITS-1:0] cnt_inc;
    logic signed [15:0]   cmp_value;
    logic                 go_right;
    logic [NB:0]          child_w;
    logic [NB-1:0]        parent;
    logic                 reach;
    out_item_t            zero_res;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res_data  = res_reg;
    assign zero_res  = '0;

    assign idx_ok    = (32'(in_data.node_index) < 32'(NODES));
    assign n_last    = (n_reg == NB'(NODES - 1));
    assign n_bottom  = (32'(n_reg) >= 32'(FIRST_BOTTOM));
    assign node_leaf = node_rd_data.leaf || n_bottom;
    assign cnt_inc   = sat_inc(cnt_rd_data);
    assign parent    = NB'((n_reg - 1'b1) >> 1);
    assign reach     = (n_reg == '0) || open_p_reg;

    // Pick the attribute that the current node splits on; unknown numbers compare zero.
    always_comb
    begin
        cmp_value = '0;
        if (32'(node_rd_data.attribute) < 32'(ATTRIBUTES))
        begin
            unique case (node_rd_data.attribute)
                3'd0:    cmp_value = item_reg.attr_0;
                3'd1:    cmp_value = item_reg.attr_1;
                3'd2:    cmp_value = item_reg.attr_2;
                3'd3:    cmp_value = item_reg.attr_3;
                3'd4:    cmp_value = item_reg.attr_4;
                3'd5:    cmp_value = item_reg.attr_5;
                default: cmp_value = '0;
            endcase
        end
    end

    assign go_right = !(cmp_value < node_rd_data.threshold);
    assign child_w  = {n_reg, 1'b0} + (go_right ? (NB + 1)'(2) : (NB + 1)'(1));

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        total_next   = total_reg;
        small_next   = small_reg;
        large_next   = large_reg;
        open_p_next  = open_p_reg;
        item_next    = item_reg;
        res_next     = res_reg;

        node_wr_en   = 1'b0;
        node_wr_addr = n_reg;
        node_wr_data = '0;
        node_rd_en   = 1'b0;
        node_rd_addr = n_reg;
        cnt_wr_en    = 1'b0;
        cnt_wr_addr  = n_reg;
        cnt_wr_data  = '0;
        cnt_rd_en    = 1'b0;
        cnt_rd_addr  = n_reg;

        unique case (state_reg)
            S_INIT:
            begin
                node_wr_en        = 1'b1;
                node_wr_data.leaf = 1'b1;
                cnt_wr_en         = 1'b1;
                n_next            = n_reg + 1'b1;
                if (n_last)
                begin
                    n_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    res_next  = zero_res;
                    n_next    = '0;
                    state_next = S_FIN;
                    unique case (in_data.operation)
                        OP_LOAD:
                        begin
                            node_wr_en             = idx_ok;
                            node_wr_addr           = NB'(in_data.node_index);
                            node_wr_data.attribute = in_data.split_attribute;
                            node_wr_data.threshold = in_data.split_value;
                            node_wr_data.leaf      = in_data.node_is_leaf;
                        end
                        OP_CLEAR:
                        begin
                            total_next = '0;
                            state_next = S_CLR;
                        end
                        OP_ROUTE:
                        begin
                            if (in_data.point_present)
                            begin
                                total_next   = sat_inc(total_reg);
                                node_rd_en   = 1'b1;
                                node_rd_addr = '0;
                                cnt_rd_en    = 1'b1;
                                cnt_rd_addr  = '0;
                                state_next   = S_WALK;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                cnt_rd_en   = 1'b1;
                                cnt_rd_addr = NB'(in_data.node_index);
                                state_next  = S_RDM;
                            end
                        end
                        OP_REPORT:
                        begin
                            small_next = total_reg;
                            large_next = '0;
                            state_next = S_SPAR;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                cnt_wr_en = 1'b1;
                n_next    = n_reg + 1'b1;
                if (n_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_WALK:
            begin
                // Count the point here, then either stop at a leaf or fetch the child.
                cnt_wr_en   = 1'b1;
                cnt_wr_data = cnt_inc;
                if (node_leaf)
                begin
                    res_next.leaf_found = 1'b1;
                    res_next.leaf_node  = 7'(n_reg);
                    res_next.node_mass  = 16'(cnt_inc);
                    state_next          = S_FIN;
                end
                else
                begin
                    n_next       = child_w[NB-1:0];
                    node_rd_en   = 1'b1;
                    node_rd_addr = child_w[NB-1:0];
                    cnt_rd_en    = 1'b1;
                    cnt_rd_addr  = child_w[NB-1:0];
                end
            end
            S_RDM:
            begin
                res_next.node_mass = 16'(cnt_rd_data);
                state_next         = S_FIN;
            end
            S_SPAR:
            begin
                if (n_reg == '0)
                begin
                    node_rd_en = 1'b1;
                    cnt_rd_en  = 1'b1;
                    state_next = S_SEVAL;
                end
                else
                begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = parent;
                    state_next   = S_SNODE;
                end
            end
            S_SNODE:
            begin
                open_p_next = node_rd_data.scan_open;
                node_rd_en  = 1'b1;
                cnt_rd_en   = 1'b1;
                state_next  = S_SEVAL;
            end
            S_SEVAL:
            begin
                node_wr_en             = 1'b1;
                node_wr_data           = node_rd_data;
                node_wr_data.scan_open = reach && !node_rd_data.leaf;
                if (reach && node_leaf)
                begin
                    if ((cnt_rd_data != '0) && (cnt_rd_data <= small_reg))
                    begin
                        small_next = cnt_rd_data;
                    end
                    if (cnt_rd_data >= large_reg)
                    begin
                        large_next = cnt_rd_data;
                    end
                end
                n_next = n_reg + 1'b1;
                if (n_last)
                begin
                    res_next.smallest_leaf = 16'(small_next);
                    res_next.largest_leaf  = 16'(large_next);
                    state_next             = S_FIN;
                end
                else
                begin
                    state_next = S_SPAR;
                end
            end
            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            n_reg     <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        small_reg  <= small_next;
        large_reg  <= large_next;
        open_p_reg <= open_p_next;
        item_reg   <= item_next;
        res_reg    <= res_next;
    end

endmodule

>>> hdl/isolation_tree_mass_router.sv
// Top level: isolation tree mass router with node table, mass store and output register.
`timescale 1ns / 1ps

// Usage
// - in_valid/in_ready/in_data carry one command beat (load node, clear masses,
//   route point, read node mass, report leaf sizes); out_valid/out_ready/out_data
//   return exactly one result beat per command, in command order.
// - Node table and mass store are synchronous RAMs of 2^(TREE_HEIGHT+1)-1 entries.
//   Routing does one read-modify-write of the mass store per tree level.
// - Clear masses sweeps the mass store, one entry a cycle.
// - Report walks every node with a parent read (none for the root), a node read and
//   a write back of the node's reach mark.
// - After reset the block sweeps both RAMs with in_ready low: every node becomes a
//   leaf and every mass zero.
// - The output register holds a result while out_ready is low; the next command beat
//   is still taken, and its result waits inside until the register frees up.
module isolation_tree_mass_router #(
    parameter int TREE_HEIGHT = 6,
    parameter int ATTRIBUTES  = 6,
    parameter int MASS_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itmr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output itmr_pkg::out_item_t out_data
);

    import itmr_pkg::*;

    localparam int NB    = TREE_HEIGHT + 1;
    localparam int NODES = (2 ** NB) - 1;

    logic                 res_valid;
    logic                 res_take;
    out_item_t            res_data;

    logic                 node_wr_en;
    logic [NB-1:0]        node_wr_addr;
    node_word_t           node_wr_data;
    logic                 node_rd_en;
    logic [NB-1:0]        node_rd_addr;
    node_word_t           node_rd_data;
    logic                 cnt_wr_en;
    logic [NB-1:0]        cnt_wr_addr;
    logic [MASS_BITS-1:0] cnt_wr_data;
    logic                 cnt_rd_en;
    logic [NB-1:0]        cnt_rd_addr;
    logic [MASS_BITS-1:0] cnt_rd_data;

    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    itmr_ctrl #(
        .TREE_HEIGHT (TREE_HEIGHT),
        .ATTRIBUTES  (ATTRIBUTES),
        .MASS_BITS   (MASS_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res_data     (res_data),
        .node_wr_en   (node_wr_en),
        .node_wr_addr (node_wr_addr),
        .node_wr_data (node_wr_data),
        .node_rd_en   (node_rd_en),
        .node_rd_addr (node_rd_addr),
        .node_rd_data (node_rd_data),
        .cnt_wr_en    (cnt_wr_en),
        .cnt_wr_addr  (cnt_wr_addr),
        .cnt_wr_data  (cnt_wr_data),
        .cnt_rd_en    (cnt_rd_en),
        .cnt_rd_addr  (cnt_rd_addr),
        .cnt_rd_data  (cnt_rd_data)
    );

    // Node table: split attribute, threshold, leaf flag and the scan reach mark.
    itmr_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    // Mass store: one saturating point count per node.
    itmr_ram #(
        .WIDTH (MASS_BITS),
        .DEPTH (NODES)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // Take a finished result when the output register is empty or draining this cycle.
    assign res_take  = res_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
